>>> design/pbi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the profile bilinear interpolator.
// No dependencies.
package pbi_pkg;

  localparam int MAX_RADIAL_DEF = 64;
  localparam int MAX_TIMES_DEF  = 64;
  localparam int MAX_KINDS_DEF  = 8;
  localparam int MAX_OUT        = 8;
  localparam int TEMP_SLOTS     = 2;
  localparam int NW             = 11;
  localparam int WQ             = 16;
  localparam int DW             = 34;

  localparam logic [2:0] MODE_RKNOT = 3'd0;
  localparam logic [2:0] MODE_TKNOT = 3'd1;
  localparam logic [2:0] MODE_DENS  = 3'd2;
  localparam logic [2:0] MODE_TEMP  = 3'd3;
  localparam logic [2:0] MODE_FLOW  = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;

  localparam logic [1:0] CFG_RHO  = 2'd0;
  localparam logic [1:0] CFG_TIME = 2'd1;
  localparam logic [1:0] CFG_SPEC = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_EDGE, S_DIV, S_CORNER, S_MUL, S_ACC, S_FMUL, S_FACC
  } state_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

endpackage

>>> design/pbi_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pbi_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for Q0.16 weights (num < den).
// Depends on pbi_pkg.
module pbi_div import pbi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  div_req_t       req,
  output logic           done,
  output logic [WQ-1:0]  quo
);

  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [WQ-1:0] quo_r;
  logic [4:0]    cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r[DW-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r <= {1'b0, req.num};
        den_r <= req.den;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? trial - {1'b0, den_r} : trial;
        quo_r <= {quo_r[WQ-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(WQ - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/pbi_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on pbi_pkg.
module pbi_mul import pbi_pkg::*; (
  input  logic                  clk,
  input  logic signed [32:0]    a,
  input  logic signed [32:0]    b,
  output logic signed [65:0]    prod
);

  logic signed [65:0] prod_r;

  assign prod = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

>>> design/profile_bilinear_interpolator.sv
`timescale 1ns / 1ps
// Top level: knot/table storage, bracket scan sequencer, bilinear interpolation.
// Depends on pbi_pkg, pbi_ram, pbi_div, pbi_mul.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+---------------------------------
//  input   | in_*                          | start & !busy
//  result  | out_*                         | out_valid strobe, one cycle
//  config  | cfg_index, cfg_data           | cfg_valid & cfg_ready
//
// A load is written to its table when accepted. A query holds busy through a scan over
// the n knots and the edge knot reads per axis, a divider wait (skipped when the weight is
// 0 or 1.0), per plane the corner reads from its table, which has a single read port,
// and three multiply/accumulate passes, and flow scaling.
// Results leave one per species the cycle after each density plane ends.
// Reset is synchronous, active low; storage is not cleared. Results cannot be held off.
module profile_bilinear_interpolator import pbi_pkg::*; #(
  parameter int MAX_RADIAL = MAX_RADIAL_DEF,
  parameter int MAX_TIMES  = MAX_TIMES_DEF,
  parameter int MAX_KINDS  = MAX_KINDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_mode,
  input  logic [5:0]         in_radial_index,
  input  logic [5:0]         in_time_index,
  input  logic [2:0]         in_species_slot,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_rho_coord,
  input  logic signed [31:0] in_time_coord,
  input  logic signed [31:0] in_radius,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  output logic [2:0]         out_species_index,
  output logic signed [31:0] out_density_value,
  output logic signed [31:0] out_temperature_value,
  output logic signed [31:0] out_flow_value,
  output logic               out_out_of_range,
  output logic               out_last
);

  localparam int RW   = $clog2(MAX_RADIAL);
  localparam int TW   = $clog2(MAX_TIMES);
  localparam int GRID = MAX_RADIAL * MAX_TIMES;
  localparam int FAW  = $clog2(GRID);
  localparam int TAW  = $clog2(TEMP_SLOTS * GRID);
  localparam int DAW  = $clog2(MAX_KINDS * GRID);
  localparam int KMAX = MAX_KINDS < MAX_OUT ? MAX_KINDS : MAX_OUT;

  state_t state_r, state_nxt;

  logic [6:0]  rho_cnt_r, time_cnt_r;
  logic [3:0]  spec_cnt_r;
  logic [NW-1:0] nr, nt, n_sel, idx_c;
  logic [3:0]  ns;

  logic        ax_r;
  logic [NW-1:0] k_r, cnt_r, ir_r, it_r;
  logic        oor_r;
  logic [1:0]  e_r;
  logic signed [31:0] ki_r;
  logic [16:0] wr_r, wt_r;
  logic [2:0]  c_r;
  logic [1:0]  l_r;
  logic [3:0]  pl_r;
  logic signed [31:0] p11_r, p12_r, p21_r, p22_r, lr1_r, lr2_r;
  logic signed [31:0] flow_r, tel_r, tion_r;
  logic signed [31:0] rc_r, tc_r, rad_r;

  logic        ov_r, oor_o_r, last_r;
  logic [2:0]  spo_r;
  logic signed [31:0] dno_r, tpo_r, flo_r;

  logic        accept, ri_ok, ti_ok, grid_ok;
  logic        rk_we, tk_we, dn_we, tp_we, fl_we;
  logic [RW-1:0]  rk_ra;
  logic [TW-1:0]  tk_ra;
  logic [DAW-1:0] dn_wa, dn_ra;
  logic [TAW-1:0] tp_wa, tp_ra;
  logic [FAW-1:0] fl_wa, fl_ra;
  logic [31:0] rk_rd, tk_rd, dn_rd, tp_rd, fl_rd;
  logic [NW-1:0] knot_ra;
  int          ld_off, rd_off;
  logic [3:0]  spec;

  logic signed [31:0] kdat, coord, pdat, la, lb, lres, fsat;
  logic [16:0] lw;
  logic signed [33:0] span, diff;
  logic        span_pos, diff_pos, w_full, need_div;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  div_req_t    div_req;
  logic        div_done;
  logic [WQ-1:0] div_quo;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid             = ov_r;
  assign out_species_index     = spo_r;
  assign out_density_value     = dno_r;
  assign out_temperature_value = tpo_r;
  assign out_flow_value        = flo_r;
  assign out_out_of_range      = oor_o_r;
  assign out_last              = last_r;

  always_comb begin
    if (NW'(rho_cnt_r) < NW'(2)) nr = NW'(2);
    else if (NW'(rho_cnt_r) > NW'(MAX_RADIAL)) nr = NW'(MAX_RADIAL);
    else nr = NW'(rho_cnt_r);
    if (NW'(time_cnt_r) < NW'(2)) nt = NW'(2);
    else if (NW'(time_cnt_r) > NW'(MAX_TIMES)) nt = NW'(MAX_TIMES);
    else nt = NW'(time_cnt_r);
    if (spec_cnt_r < 4'd2) ns = 4'd2;
    else if (spec_cnt_r > 4'(KMAX)) ns = 4'(KMAX);
    else ns = spec_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_cnt_r  <= 7'd64;
      time_cnt_r <= 7'd64;
      spec_cnt_r <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RHO:  rho_cnt_r  <= cfg_data;
        CFG_TIME: time_cnt_r <= cfg_data;
        CFG_SPEC: spec_cnt_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // load path
  assign ri_ok   = int'(in_radial_index) < MAX_RADIAL;
  assign ti_ok   = int'(in_time_index) < MAX_TIMES;
  assign grid_ok = ri_ok && ti_ok;
  assign ld_off  = int'(in_time_index) * MAX_RADIAL + int'(in_radial_index);
  assign rk_we   = accept && in_mode == MODE_RKNOT && ri_ok;
  assign tk_we   = accept && in_mode == MODE_TKNOT && ti_ok;
  assign dn_we   = accept && in_mode == MODE_DENS && grid_ok &&
                   int'(in_species_slot) < MAX_KINDS;
  assign tp_we   = accept && in_mode == MODE_TEMP && grid_ok &&
                   int'(in_species_slot) < TEMP_SLOTS;
  assign fl_we   = accept && in_mode == MODE_FLOW && grid_ok;
  assign dn_wa   = DAW'(int'(in_species_slot) * GRID + ld_off);
  assign tp_wa   = TAW'(int'(in_species_slot) * GRID + ld_off);
  assign fl_wa   = FAW'(ld_off);

  // read path
  assign spec    = pl_r - 4'd3;
  assign rd_off  = (int'(it_r) + int'(c_r[1])) * MAX_RADIAL + int'(ir_r) + int'(c_r[0]);
  assign dn_ra   = DAW'(int'(spec) * GRID + rd_off);
  assign tp_ra   = TAW'((pl_r == 4'd2 ? GRID : 0) + rd_off);
  assign fl_ra   = FAW'(rd_off);
  assign knot_ra = (state_r == S_EDGE) ? ((e_r == 2'd0) ? idx_c : idx_c + NW'(1)) : k_r;
  assign rk_ra   = knot_ra[RW-1:0];
  assign tk_ra   = knot_ra[TW-1:0];

  pbi_ram #(.WIDTH(32), .DEPTH(MAX_RADIAL)) u_rknot (
    .clk(clk), .we(rk_we), .waddr(RW'(in_radial_index)), .wdata(in_load_value),
    .raddr(rk_ra), .rdata(rk_rd));
  pbi_ram #(.WIDTH(32), .DEPTH(MAX_TIMES)) u_tknot (
    .clk(clk), .we(tk_we), .waddr(TW'(in_time_index)), .wdata(in_load_value),
    .raddr(tk_ra), .rdata(tk_rd));
  pbi_ram #(.WIDTH(32), .DEPTH(MAX_KINDS * GRID)) u_dens (
    .clk(clk), .we(dn_we), .waddr(dn_wa), .wdata(in_load_value),
    .raddr(dn_ra), .rdata(dn_rd));
  pbi_ram #(.WIDTH(32), .DEPTH(TEMP_SLOTS * GRID)) u_temp (
    .clk(clk), .we(tp_we), .waddr(tp_wa), .wdata(in_load_value),
    .raddr(tp_ra), .rdata(tp_rd));
  pbi_ram #(.WIDTH(32), .DEPTH(GRID)) u_flow (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(in_load_value),
    .raddr(fl_ra), .rdata(fl_rd));

  pbi_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quo(div_quo));
  pbi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // bracket and interpolation datapath helpers
  assign kdat  = ax_r ? $signed(tk_rd) : $signed(rk_rd);
  assign coord = ax_r ? tc_r : rc_r;
  assign n_sel = ax_r ? nt : nr;
  assign pdat  = (pl_r == 4'd0) ? $signed(fl_rd) : (pl_r < 4'd3 ? $signed(tp_rd) : $signed(dn_rd));

  always_comb begin
    idx_c = (cnt_r == '0) ? '0 : cnt_r - NW'(1);
    if (idx_c > n_sel - NW'(2)) idx_c = n_sel - NW'(2);
  end

  assign span     = 34'(kdat) - 34'(ki_r);
  assign diff     = 34'(coord) - 34'(ki_r);
  assign span_pos = !span[33] && span != '0;
  assign diff_pos = !diff[33] && diff != '0;
  assign w_full   = diff >= span;
  assign need_div = span_pos && diff_pos && !w_full;

  always_comb begin
    case (l_r)
      2'd0:    begin la = p11_r; lb = p12_r; end
      2'd1:    begin la = p21_r; lb = p22_r; end
      default: begin la = lr1_r; lb = lr2_r; end
    endcase
    lw   = (l_r == 2'd2) ? wt_r : wr_r;
    lres = la + prod[47:16];
    if (!prod[65] && (|prod[64:47])) fsat = 32'sh7FFFFFFF;
    else if (prod[65] && !(&prod[64:47])) fsat = 32'sh80000000;
    else fsat = prod[47:16];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && in_mode == MODE_QUERY) state_nxt = S_SCAN;
      S_SCAN:   if (k_r == n_sel) state_nxt = S_EDGE;
      S_EDGE: begin
        if (e_r == 2'd2) begin
          if (need_div) state_nxt = S_DIV;
          else state_nxt = ax_r ? S_CORNER : S_SCAN;
        end
      end
      S_DIV:    if (div_done) state_nxt = ax_r ? S_CORNER : S_SCAN;
      S_CORNER: if (c_r == 3'd4) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ACC;
      S_ACC: begin
        if (l_r != 2'd2) state_nxt = S_MUL;
        else if (pl_r == 4'd0) state_nxt = S_FMUL;
        else if (pl_r >= 4'd3 && spec + 4'd1 == ns) state_nxt = S_IDLE;
        else state_nxt = S_CORNER;
      end
      S_FMUL:   state_nxt = S_FACC;
      S_FACC:   state_nxt = S_CORNER;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = diff;
    div_req.den   = span;
    mul_a         = 33'(lb) - 33'(la);
    mul_b         = 33'(lw);
    unique case (state_r)
      S_EDGE:  div_req.start = (e_r == 2'd2) && need_div;
      S_FMUL: begin
        mul_a = 33'(flow_r);
        mul_b = 33'(rad_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= 1'b0;
      if (state_r == S_ACC && l_r == 2'd2 && pl_r >= 4'd3) begin
        ov_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        rc_r  <= in_rho_coord;
        tc_r  <= in_time_coord;
        rad_r <= in_radius;
        ax_r  <= 1'b0;
        k_r   <= '0;
        cnt_r <= '0;
        oor_r <= 1'b0;
      end
      S_SCAN: begin
        if (k_r != n_sel) k_r <= k_r + NW'(1);
        if (k_r != '0) begin
          if (k_r == NW'(1) && coord < kdat) oor_r <= 1'b1;
          if (k_r != NW'(1) && kdat <= coord) cnt_r <= cnt_r + NW'(1);
          if (k_r == n_sel && coord >= kdat) oor_r <= 1'b1;
        end
        e_r <= '0;
      end
      S_EDGE: begin
        e_r <= e_r + 2'd1;
        if (e_r == 2'd1) ki_r <= kdat;
        if (e_r == 2'd2) begin
          if (ax_r) it_r <= idx_c;
          else ir_r <= idx_c;
          if (!need_div) begin
            if (ax_r) wt_r <= (span_pos && diff_pos) ? 17'h10000 : '0;
            else wr_r <= (span_pos && diff_pos) ? 17'h10000 : '0;
            ax_r  <= 1'b1;
            k_r   <= '0;
            cnt_r <= '0;
            c_r   <= '0;
            pl_r  <= '0;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (ax_r) wt_r <= 17'(div_quo);
          else wr_r <= 17'(div_quo);
          ax_r  <= 1'b1;
          k_r   <= '0;
          cnt_r <= '0;
          c_r   <= '0;
          pl_r  <= '0;
        end
      end
      S_CORNER: begin
        c_r <= c_r + 3'd1;
        l_r <= '0;
        case (c_r)
          3'd1:    p11_r <= pdat;
          3'd2:    p12_r <= pdat;
          3'd3:    p21_r <= pdat;
          3'd4:    p22_r <= pdat;
          default: ;
        endcase
      end
      S_ACC: begin
        l_r <= l_r + 2'd1;
        c_r <= '0;
        case (l_r)
          2'd0: lr1_r <= lres;
          2'd1: lr2_r <= lres;
          default: begin
            pl_r <= pl_r + 4'd1;
            if (pl_r == 4'd0) flow_r <= lres;
            else if (pl_r == 4'd1) tel_r <= lres;
            else if (pl_r == 4'd2) tion_r <= lres;
            else begin
              spo_r   <= spec[2:0];
              dno_r   <= lres;
              tpo_r   <= (spec == 4'd0) ? tel_r : tion_r;
              flo_r   <= flow_r;
              oor_o_r <= oor_r;
              last_r  <= (spec + 4'd1 == ns);
            end
          end
        endcase
      end
      S_FACC: begin
        flow_r <= fsat;
        c_r    <= '0;
      end
      default: ;
    endcase
  end

endmodule
